// ----- rtl/assert_macros.svh -----
// Assertion macros used by the evictor top module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/lbe_pkg.sv -----
// Types, constants and helpers for the LRU budget evictor.
package lbe_pkg;

    localparam int NUM_SLOTS    = 16;
    localparam int SLOT_W       = $clog2(NUM_SLOTS);
    localparam int CNT_W        = 32;
    localparam int TICK_W       = 64;
    localparam int TOT_W        = CNT_W + SLOT_W;
    localparam int OUT_TOT_W    = 36;
    localparam int SAT_W        = (TOT_W > OUT_TOT_W) ? TOT_W : OUT_TOT_W;
    localparam int MAX_RESULTS  = 16;
    localparam int RES_W        = $clog2(MAX_RESULTS + 1);
    localparam int PIN_W        = 16;
    localparam int SLOT_FIELD_W = 4;

    localparam logic [OUT_TOT_W-1:0] TOTAL_MAX = {OUT_TOT_W{1'b1}};

    typedef enum logic [1:0] {
        REQ_SET_COUNT = 2'd0,
        REQ_TOUCH     = 2'd1,
        REQ_ENFORCE   = 2'd2,
        REQ_FORGET    = 2'd3
    } lbe_req_t;

    typedef struct packed {
        lbe_req_t                  req_type;
        logic [SLOT_FIELD_W-1:0]   slot;
        logic [CNT_W-1:0]          change_count;
        logic [PIN_W-1:0]          pin_mask;
    } lbe_in_t;

    typedef struct packed {
        logic                      victim_valid;
        logic [SLOT_FIELD_W-1:0]   victim_slot;
        logic [OUT_TOT_W-1:0]      total_loaded;
        logic                      still_over;
        logic                      last;
    } lbe_out_t;

    function automatic logic [OUT_TOT_W-1:0] sat_total(input logic [TOT_W-1:0] t);
        logic [SAT_W-1:0] w;
        w = SAT_W'(t);
        sat_total = (w > SAT_W'(TOTAL_MAX)) ? TOTAL_MAX : OUT_TOT_W'(w);
    endfunction

endpackage

// ----- rtl/lru_budget_evictor_top.sv -----
// LRU budget evictor: slot table in RAM, sequential oldest-victim scan.
//
//   channel | signals                      | beat
//   --------+------------------------------+---------------------------------
//   in      | in_valid, in_stall, in_data  | one request (lbe_in_t)
//   out     | out_valid, out_stall,        | one result (lbe_out_t)
//           | out_data                     |
//   cfg     | cfg_we, cfg_wdata            | budget register write
//
// Set count reads the slot's old count, then writes the new one; touch writes
// the tick; forget and an enforce with nothing to do go straight to output.
// An enforce makes one pass over the slot RAMs per eviction, then update and
// output; a pass with no victim ends it. Up to 16 evictions per enforce.
// Reset clears per-slot valid bits at once; there is no clearing pass.
// Results wait in one output register; a new request is taken once the last
// result of the previous one has been registered.
`include "assert_macros.svh"

module lru_budget_evictor_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  lbe_pkg::lbe_in_t    in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output lbe_pkg::lbe_out_t   out_data,
    input  logic                cfg_we,
    input  logic [35:0]         cfg_wdata
);

    localparam int NUM_SLOTS   = lbe_pkg::NUM_SLOTS;
    localparam int SLOT_W      = lbe_pkg::SLOT_W;
    localparam int CNT_W       = lbe_pkg::CNT_W;
    localparam int TICK_W      = lbe_pkg::TICK_W;
    localparam int TOT_W       = lbe_pkg::TOT_W;
    localparam int OUT_TOT_W   = lbe_pkg::OUT_TOT_W;
    localparam int SAT_W       = lbe_pkg::SAT_W;
    localparam int RES_W       = lbe_pkg::RES_W;
    localparam int PIN_W       = lbe_pkg::PIN_W;
    localparam int SF_W        = lbe_pkg::SLOT_FIELD_W;
    localparam logic [SLOT_W:0] SCAN_END = (SLOT_W + 1)'(NUM_SLOTS);
    localparam logic [RES_W-1:0] RES_MAX = RES_W'(lbe_pkg::MAX_RESULTS);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_SET_RD = 8'b0000_0010,
        ST_SET_WR = 8'b0000_0100,
        ST_TOUCH  = 8'b0000_1000,
        ST_SCAN   = 8'b0001_0000,
        ST_EVICT  = 8'b0010_0000,
        ST_NEXT   = 8'b0100_0000,
        ST_EMIT   = 8'b1000_0000
    } state_t;

    state_t                   state_reg, state_next;
    lbe_pkg::lbe_in_t         req_reg, req_next;
    logic [OUT_TOT_W-1:0]     limit_reg, limit_next;
    logic [TOT_W-1:0]         total_reg, total_next;
    logic [TICK_W-1:0]        tick_clk_reg, tick_clk_next;
    logic [NUM_SLOTS-1:0]     cnt_vld_reg, cnt_vld_next;
    logic [NUM_SLOTS-1:0]     tick_vld_reg, tick_vld_next;
    logic [SLOT_W:0]          scan_cnt_reg, scan_cnt_next;
    logic                     cmp_pend_reg, cmp_pend_next;
    logic [SLOT_W-1:0]        cmp_idx_reg, cmp_idx_next;
    logic                     found_reg, found_next;
    logic [SLOT_W-1:0]        best_idx_reg, best_idx_next;
    logic [TICK_W-1:0]        best_tick_reg, best_tick_next;
    logic [CNT_W-1:0]         best_cnt_reg, best_cnt_next;
    logic                     pend_vld_reg, pend_vld_next;
    logic [SLOT_W-1:0]        pend_slot_reg, pend_slot_next;
    logic [RES_W-1:0]         n_reg, n_next;
    logic                     cont_reg, cont_next;
    logic                     over_reg, over_next;
    lbe_pkg::lbe_out_t        res_reg, res_next;
    logic                     out_valid_reg, out_valid_next;
    lbe_pkg::lbe_out_t        out_data_reg, out_data_next;

    logic                     in_acc;
    logic                     in_slot_ok;
    logic                     out_free;
    logic [SLOT_W-1:0]        ram_raddr;
    logic [SLOT_W-1:0]        ram_waddr;
    logic                     cnt_we;
    logic [CNT_W-1:0]         cnt_rdata;
    logic                     tick_we;
    logic [TICK_W-1:0]        tick_wdata;
    logic [TICK_W-1:0]        tick_rdata;
    logic [CNT_W-1:0]         cnt_eff;
    logic [TICK_W-1:0]        tick_eff;
    logic [SF_W-1:0]          pin_idx;
    logic                     pinned;
    logic                     cand;
    logic [TOT_W-1:0]         evict_total;
    logic [RES_W-1:0]         n_inc;
    logic                     evict_over;

    function automatic lbe_pkg::lbe_out_t mk_res(
        input logic               vv,
        input logic [SLOT_W-1:0]  vs,
        input logic [TOT_W-1:0]   tot,
        input logic               so,
        input logic               lst
    );
        lbe_pkg::lbe_out_t r;
        r.victim_valid = vv;
        r.victim_slot  = SF_W'(vs);
        r.total_loaded = lbe_pkg::sat_total(tot);
        r.still_over   = so;
        r.last         = lst;
        mk_res = r;
    endfunction

    lbe_ram #(.WIDTH(CNT_W), .DEPTH(NUM_SLOTS)) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (ram_waddr),
        .wdata (req_reg.change_count),
        .raddr (ram_raddr),
        .rdata (cnt_rdata)
    );

    lbe_ram #(.WIDTH(TICK_W), .DEPTH(NUM_SLOTS)) u_tick_ram (
        .clk   (clk),
        .we    (tick_we),
        .waddr (ram_waddr),
        .wdata (tick_wdata),
        .raddr (ram_raddr),
        .rdata (tick_rdata)
    );

    assign in_stall   = (state_reg != ST_IDLE);
    assign in_acc     = in_valid && (state_reg == ST_IDLE);
    assign in_slot_ok = (int'(in_data.slot) < NUM_SLOTS);
    assign out_free   = !out_valid_reg || !out_stall;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

    assign ram_waddr  = SLOT_W'(req_reg.slot);
    assign ram_raddr  = (state_reg == ST_SET_RD) ? ram_waddr : scan_cnt_reg[SLOT_W-1:0];
    assign tick_wdata = tick_clk_reg + TICK_W'(1);

    assign cnt_eff  = cnt_vld_reg[cmp_idx_reg] ? cnt_rdata : '0;
    assign tick_eff = tick_vld_reg[cmp_idx_reg] ? tick_rdata : '0;
    assign pin_idx  = SF_W'(cmp_idx_reg);
    assign pinned   = (int'(cmp_idx_reg) < PIN_W) && req_reg.pin_mask[pin_idx];
    assign cand     = cmp_pend_reg && (cnt_eff != '0) && !pinned;

    assign evict_total = total_reg - TOT_W'(best_cnt_reg);
    assign n_inc       = n_reg + RES_W'(1);
    assign evict_over  = SAT_W'(evict_total) > SAT_W'(limit_reg);

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        limit_next     = cfg_we ? cfg_wdata : limit_reg;
        total_next     = total_reg;
        tick_clk_next  = tick_clk_reg;
        cnt_vld_next   = cnt_vld_reg;
        tick_vld_next  = tick_vld_reg;
        scan_cnt_next  = scan_cnt_reg;
        cmp_pend_next  = cmp_pend_reg;
        cmp_idx_next   = cmp_idx_reg;
        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        best_tick_next = best_tick_reg;
        best_cnt_next  = best_cnt_reg;
        pend_vld_next  = pend_vld_reg;
        pend_slot_next = pend_slot_reg;
        n_next         = n_reg;
        cont_next      = cont_reg;
        over_next      = over_reg;
        res_next       = res_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && out_stall;
        cnt_we         = 1'b0;
        tick_we        = 1'b0;

        if (cand && (!found_reg || (tick_eff < best_tick_reg)))
        begin
            found_next     = 1'b1;
            best_idx_next  = cmp_idx_reg;
            best_tick_next = tick_eff;
            best_cnt_next  = cnt_eff;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    req_next = in_data;
                    res_next = mk_res(1'b0, '0, total_reg, 1'b0, 1'b1);
                    state_next = ST_EMIT;
                    unique case (in_data.req_type)
                        lbe_pkg::REQ_SET_COUNT:
                        begin
                            if (in_slot_ok)
                            begin
                                state_next = ST_SET_RD;
                            end
                        end
                        lbe_pkg::REQ_TOUCH:
                        begin
                            if (in_slot_ok)
                            begin
                                state_next = ST_TOUCH;
                            end
                        end
                        lbe_pkg::REQ_FORGET:
                        begin
                            tick_vld_next = '0;
                        end
                        lbe_pkg::REQ_ENFORCE:
                        begin
                            n_next        = '0;
                            pend_vld_next = 1'b0;
                            if ((limit_reg != '0) && (SAT_W'(total_reg) > SAT_W'(limit_reg)))
                            begin
                                scan_cnt_next = '0;
                                cmp_pend_next = 1'b0;
                                found_next    = 1'b0;
                                state_next    = ST_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_SET_RD:
            begin
                state_next = ST_SET_WR;
            end
            ST_SET_WR:
            begin
                cnt_we                  = 1'b1;
                cnt_vld_next[ram_waddr] = 1'b1;
                total_next = total_reg
                           - TOT_W'(cnt_vld_reg[ram_waddr] ? cnt_rdata : '0)
                           + TOT_W'(req_reg.change_count);
                res_next   = mk_res(1'b0, '0, total_next, 1'b0, 1'b1);
                state_next = ST_EMIT;
            end
            ST_TOUCH:
            begin
                tick_we                  = 1'b1;
                tick_clk_next            = tick_wdata;
                tick_vld_next[ram_waddr] = 1'b1;
                state_next               = ST_EMIT;
            end
            ST_SCAN:
            begin
                cmp_idx_next  = scan_cnt_reg[SLOT_W-1:0];
                cmp_pend_next = (scan_cnt_reg != SCAN_END);
                if (scan_cnt_reg != SCAN_END)
                begin
                    scan_cnt_next = scan_cnt_reg + (SLOT_W + 1)'(1);
                end
                else
                begin
                    state_next = ST_EVICT;
                end
            end
            ST_EVICT:
            begin
                if (!found_reg)
                begin
                    res_next   = mk_res(pend_vld_reg, pend_vld_reg ? pend_slot_reg : '0,
                                        total_reg, 1'b1, 1'b1);
                    state_next = ST_EMIT;
                end
                else
                begin
                    total_next                  = evict_total;
                    cnt_vld_next[best_idx_reg]  = 1'b0;
                    tick_vld_next[best_idx_reg] = 1'b0;
                    n_next                      = n_inc;
                    over_next                   = evict_over;
                    cont_next                   = evict_over && (n_inc < RES_MAX);
                    if (pend_vld_reg)
                    begin
                        res_next   = mk_res(1'b1, pend_slot_reg, evict_total, 1'b0, 1'b0);
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_NEXT;
                    end
                end
            end
            ST_NEXT:
            begin
                if (cont_reg)
                begin
                    pend_vld_next  = 1'b1;
                    pend_slot_next = best_idx_reg;
                    scan_cnt_next  = '0;
                    cmp_pend_next  = 1'b0;
                    found_next     = 1'b0;
                    state_next     = ST_SCAN;
                end
                else
                begin
                    res_next   = mk_res(1'b1, best_idx_reg, total_reg, over_reg, 1'b1);
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = res_reg.last ? ST_IDLE : ST_NEXT;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            limit_reg     <= '0;
            total_reg     <= '0;
            tick_clk_reg  <= '0;
            cnt_vld_reg   <= '0;
            tick_vld_reg  <= '0;
            scan_cnt_reg  <= '0;
            cmp_pend_reg  <= 1'b0;
            found_reg     <= 1'b0;
            pend_vld_reg  <= 1'b0;
            n_reg         <= '0;
            cont_reg      <= 1'b0;
            over_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            limit_reg     <= limit_next;
            total_reg     <= total_next;
            tick_clk_reg  <= tick_clk_next;
            cnt_vld_reg   <= cnt_vld_next;
            tick_vld_reg  <= tick_vld_next;
            scan_cnt_reg  <= scan_cnt_next;
            cmp_pend_reg  <= cmp_pend_next;
            found_reg     <= found_next;
            pend_vld_reg  <= pend_vld_next;
            n_reg         <= n_next;
            cont_reg      <= cont_next;
            over_reg      <= over_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        cmp_idx_reg   <= cmp_idx_next;
        best_idx_reg  <= best_idx_next;
        best_tick_reg <= best_tick_next;
        best_cnt_reg  <= best_cnt_next;
        pend_slot_reg <= pend_slot_next;
        res_reg       <= res_next;
        out_data_reg  <= out_data_next;
    end

    `ASSERT_IMP(a_mid_beat_has_victim, out_valid_reg && !out_data_reg.last, out_data_reg.victim_valid, "non-final beat without victim")
    `ASSERT_IMP(a_still_over_on_last, out_valid_reg && out_data_reg.still_over, out_data_reg.last, "still_over on non-final beat")
    `ASSERT_IMP(a_victim_loaded, (state_reg == ST_EVICT) && found_reg, best_cnt_reg != '0, "evicting an empty slot")
    `ASSERT_NXT(a_forget_clears, in_acc && (in_data.req_type == lbe_pkg::REQ_FORGET), tick_vld_reg == '0, "forget left ticks")

endmodule

// ----- rtl/lbe_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module lbe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
